/* hdl/sws_pkg.sv */
// Package with the shared constants and codes of the sliding window statistics block.
package sws_pkg;

  localparam int unsigned SUM_W   = 40;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CNT_O_W = 9;
  localparam int unsigned DIV_CW  = 6;

  localparam logic [VAL_W-1:0] PERIOD_RESET = 32'd60000;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_REPORT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [1:0] OC_OK        = 2'd0;
  localparam logic [1:0] OC_FAILED    = 2'd1;
  localparam logic [1:0] OC_CANCELLED = 2'd2;
  localparam logic [1:0] OC_OTHER     = 2'd3;

  localparam logic [1:0] SLOT_OK        = 2'd0;
  localparam logic [1:0] SLOT_FAILED    = 2'd1;
  localparam logic [1:0] SLOT_CANCELLED = 2'd2;

endpackage

/* hdl/sliding_window_duration_stats_top.sv */
// Sliding window query statistics: record ring, expiry, rescan and averaging.
// A record beat pushes one entry; when the ring is full it first expires its oldest entry.
// A report beat checks the oldest records for expiry, reads every ring entry when a min or max
// rescan runs, and runs one shared 40-step serial divider for each average with a nonzero count.
// One beat is worked on at a time; the result sits in an output register until taken.
// Reset empties the ring and statistics and sets the window period to 60000 ms.
module sliding_window_duration_stats_top #(
  parameter int unsigned RING_DEPTH = 256,
  parameter int unsigned TIME_BITS  = 48
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sws_pkg::VAL_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           mode_i,
  input  logic [TIME_BITS-1:0]                 now_ms_i,
  input  logic [1:0]                           outcome_i,
  input  logic [sws_pkg::VAL_W-1:0]            wait_ms_i,
  input  logic                                 exec_present_i,
  input  logic [sws_pkg::VAL_W-1:0]            exec_ms_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [sws_pkg::CNT_O_W-1:0]          ok_count_o,
  output logic [sws_pkg::CNT_O_W-1:0]          failed_count_o,
  output logic [sws_pkg::CNT_O_W-1:0]          cancelled_count_o,
  output logic [sws_pkg::VAL_W-1:0]            wait_min_ms_o,
  output logic [sws_pkg::VAL_W-1:0]            wait_max_ms_o,
  output logic [sws_pkg::VAL_W-1:0]            wait_avg_ms_o,
  output logic [sws_pkg::VAL_W-1:0]            exec_min_ms_o,
  output logic [sws_pkg::VAL_W-1:0]            exec_max_ms_o,
  output logic [sws_pkg::VAL_W-1:0]            exec_avg_ms_o,
  output logic                                 overflow_o
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam int unsigned VW = sws_pkg::VAL_W;
  localparam int unsigned SW = sws_pkg::SUM_W;
  localparam int unsigned OW = sws_pkg::CNT_O_W;
  localparam int unsigned DW = sws_pkg::DIV_CW;

  typedef struct packed {
    logic [TIME_BITS-1:0] tstamp;
    logic [1:0]           oc;
    logic [VW-1:0]        wait_v;
    logic                 ev;
    logic [VW-1:0]        exec_v;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_REC_RD, S_REC_EXP, S_REC_PUSH, S_EXP_RD, S_EXP_CHK, S_POST,
    S_SCAN_RD, S_SCAN_UPD, S_DIV_INIT, S_DIV, S_OUT
  } state_e;

  state_e state_q;

  rec_t mem [RING_DEPTH];
  rec_t rd_q;
  logic rd_en;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  rec_t wr_data;

  logic [VW-1:0]        period_q;
  logic [TIME_BITS-1:0] limit_q;
  logic [1:0]           oc_q;
  logic [VW-1:0]        wait_q;
  logic                 ev_q;
  logic [VW-1:0]        exec_q;
  logic [AW-1:0]        head_q;
  logic [CW-1:0]        fill_q;
  logic [CW-1:0]        cnt_q [3];
  logic [SW-1:0]        sum_q [2];
  logic [CW-1:0]        scnt_q [2];
  logic [VW-1:0]        min_q [2];
  logic [VW-1:0]        max_q [2];
  logic                 pending_q;
  logic                 overflow_q;
  logic                 chk_q;
  logic [CW-1:0]        scan_n_q;
  logic [AW-1:0]        scan_idx_q;
  logic [VW-1:0]        avg_q [2];
  logic [CW-1:0]        div_rem_q;
  logic [SW-1:0]        div_quo_q;
  logic [DW-1:0]        div_cnt_q;
  logic                 div_s_q;

  logic                 out_valid_q;
  logic [OW-1:0]        o_cnt_q [3];
  logic [VW-1:0]        o_min_q [2];
  logic [VW-1:0]        o_max_q [2];
  logic [VW-1:0]        o_avg_q [2];
  logic                 o_ovf_q;

  logic                 accept;
  logic [CW:0]          wsum;
  logic [AW-1:0]        head_inc;
  logic [AW-1:0]        scan_inc;
  logic                 expired;
  logic                 do_remove;
  logic [1:0]           rd_slot;
  logic [1:0]           in_slot;
  logic [CW:0]          div_shift;
  logic                 div_ge;
  logic [CW:0]          div_rem_d;
  logic [SW-1:0]        div_quo_d;
  logic [TIME_BITS-1:0] period_ext;
  logic                 out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign period_ext = TIME_BITS'(period_q);

  assign wsum     = (CW+1)'(head_q) + (CW+1)'(fill_q);
  assign wr_addr  = (wsum >= (CW+1)'(RING_DEPTH)) ? AW'(wsum - (CW+1)'(RING_DEPTH))
                                                  : AW'(wsum);
  assign head_inc = (head_q == AW'(RING_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign scan_inc = (scan_idx_q == AW'(RING_DEPTH - 1)) ? '0 : scan_idx_q + AW'(1);

  assign rd_en   = (state_q == S_REC_RD) || (state_q == S_EXP_RD) || (state_q == S_SCAN_RD);
  assign rd_addr = (state_q == S_SCAN_RD) ? scan_idx_q : head_q;
  assign wr_en   = (state_q == S_REC_PUSH);
  assign wr_data = '{tstamp: limit_q, oc: oc_q, wait_v: wait_q, ev: ev_q,
                     exec_v: ev_q ? exec_q : '0};

  assign expired   = rd_q.tstamp < limit_q;
  assign do_remove = (state_q == S_REC_EXP) || ((state_q == S_EXP_CHK) && expired);
  assign rd_slot   = (rd_q.oc == sws_pkg::OC_OK) ? sws_pkg::SLOT_OK :
                     (rd_q.oc == sws_pkg::OC_CANCELLED) ? sws_pkg::SLOT_CANCELLED :
                     sws_pkg::SLOT_FAILED;
  assign in_slot   = (oc_q == sws_pkg::OC_OK) ? sws_pkg::SLOT_OK :
                     (oc_q == sws_pkg::OC_CANCELLED) ? sws_pkg::SLOT_CANCELLED :
                     sws_pkg::SLOT_FAILED;

  assign div_shift = {div_rem_q, div_quo_q[SW-1]};
  assign div_ge    = div_shift >= {1'b0, scnt_q[div_s_q]};
  assign div_rem_d = div_ge ? div_shift - {1'b0, scnt_q[div_s_q]} : div_shift;
  assign div_quo_d = {div_quo_q[SW-2:0], div_ge};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      period_q    <= sws_pkg::PERIOD_RESET;
      head_q      <= '0;
      fill_q      <= '0;
      pending_q   <= 1'b0;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
      limit_q     <= '0;
      oc_q        <= '0;
      wait_q      <= '0;
      ev_q        <= 1'b0;
      exec_q      <= '0;
      chk_q       <= 1'b0;
      scan_n_q    <= '0;
      scan_idx_q  <= '0;
      div_rem_q   <= '0;
      div_quo_q   <= '0;
      div_cnt_q   <= '0;
      div_s_q     <= 1'b0;
      o_ovf_q     <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        cnt_q[k]   <= '0;
        o_cnt_q[k] <= '0;
      end
      for (int s = 0; s < 2; s++) begin
        sum_q[s]   <= '0;
        scnt_q[s]  <= '0;
        min_q[s]   <= '1;
        max_q[s]   <= '0;
        avg_q[s]   <= '0;
        o_min_q[s] <= '0;
        o_max_q[s] <= '0;
        o_avg_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end

      if (do_remove) begin
        if (cnt_q[rd_slot] != '0) cnt_q[rd_slot] <= cnt_q[rd_slot] - CW'(1);
        sum_q[0] <= sum_q[0] - SW'(rd_q.wait_v);
        if (scnt_q[0] != '0) scnt_q[0] <= scnt_q[0] - CW'(1);
        if (rd_q.wait_v == min_q[0] || rd_q.wait_v == max_q[0] ||
            (rd_q.ev && (rd_q.exec_v == min_q[1] || rd_q.exec_v == max_q[1]))) begin
          pending_q <= 1'b1;
        end
        if (rd_q.ev) begin
          sum_q[1] <= sum_q[1] - SW'(rd_q.exec_v);
          if (scnt_q[1] != '0) scnt_q[1] <= scnt_q[1] - CW'(1);
        end
        head_q <= head_inc;
        fill_q <= fill_q - CW'(1);
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            oc_q    <= outcome_i;
            wait_q  <= wait_ms_i;
            ev_q    <= exec_present_i;
            exec_q  <= exec_ms_i;
            limit_q <= (mode_i == sws_pkg::MODE_REPORT) ? now_ms_i - period_ext : now_ms_i;
            chk_q   <= (fill_q != '0);
            priority if (mode_i == sws_pkg::MODE_RECORD) begin
              state_q <= (fill_q >= CW'(RING_DEPTH)) ? S_REC_RD : S_REC_PUSH;
            end else if (mode_i == sws_pkg::MODE_REPORT) begin
              if (fill_q != '0 && now_ms_i >= period_ext) state_q <= S_EXP_RD;
              else state_q <= S_POST;
            end else if (mode_i == sws_pkg::MODE_CLEAR) begin
              head_q     <= '0;
              fill_q     <= '0;
              pending_q  <= 1'b0;
              overflow_q <= 1'b0;
              for (int k = 0; k < 3; k++) cnt_q[k] <= '0;
              for (int s = 0; s < 2; s++) begin
                sum_q[s]  <= '0;
                scnt_q[s] <= '0;
                min_q[s]  <= '1;
                max_q[s]  <= '0;
              end
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_REC_RD: state_q <= S_REC_EXP;
        S_REC_EXP: begin
          overflow_q <= 1'b1;
          state_q    <= S_REC_PUSH;
        end
        S_REC_PUSH: begin
          cnt_q[in_slot] <= cnt_q[in_slot] + CW'(1);
          sum_q[0]  <= sum_q[0] + SW'(wait_q);
          scnt_q[0] <= scnt_q[0] + CW'(1);
          if (wait_q < min_q[0]) min_q[0] <= wait_q;
          if (wait_q > max_q[0]) max_q[0] <= wait_q;
          if (ev_q) begin
            sum_q[1]  <= sum_q[1] + SW'(exec_q);
            scnt_q[1] <= scnt_q[1] + CW'(1);
            if (exec_q < min_q[1]) min_q[1] <= exec_q;
            if (exec_q > max_q[1]) max_q[1] <= exec_q;
          end
          fill_q  <= fill_q + CW'(1);
          state_q <= S_IDLE;
        end
        S_EXP_RD: state_q <= (fill_q == '0) ? S_POST : S_EXP_CHK;
        S_EXP_CHK: state_q <= expired ? S_EXP_RD : S_POST;
        S_POST: begin
          if (chk_q && pending_q) begin
            for (int s = 0; s < 2; s++) begin
              min_q[s] <= '1;
              max_q[s] <= '0;
            end
            scan_n_q   <= '0;
            scan_idx_q <= head_q;
            state_q    <= S_SCAN_RD;
          end else begin
            div_s_q <= 1'b0;
            state_q <= S_DIV_INIT;
          end
        end
        S_SCAN_RD: begin
          if (scan_n_q == fill_q) begin
            pending_q <= 1'b0;
            div_s_q   <= 1'b0;
            state_q   <= S_DIV_INIT;
          end else begin
            state_q <= S_SCAN_UPD;
          end
        end
        S_SCAN_UPD: begin
          if (rd_q.wait_v < min_q[0]) min_q[0] <= rd_q.wait_v;
          if (rd_q.wait_v > max_q[0]) max_q[0] <= rd_q.wait_v;
          if (rd_q.ev) begin
            if (rd_q.exec_v < min_q[1]) min_q[1] <= rd_q.exec_v;
            if (rd_q.exec_v > max_q[1]) max_q[1] <= rd_q.exec_v;
          end
          scan_n_q   <= scan_n_q + CW'(1);
          scan_idx_q <= scan_inc;
          state_q    <= S_SCAN_RD;
        end
        S_DIV_INIT: begin
          if (scnt_q[div_s_q] == '0) begin
            avg_q[div_s_q] <= '0;
            div_s_q        <= 1'b1;
            state_q        <= div_s_q ? S_OUT : S_DIV_INIT;
          end else begin
            div_rem_q <= '0;
            div_quo_q <= sum_q[div_s_q];
            div_cnt_q <= DW'(SW);
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          div_rem_q <= div_rem_d[CW-1:0];
          div_quo_q <= div_quo_d;
          div_cnt_q <= div_cnt_q - DW'(1);
          if (div_cnt_q == DW'(1)) begin
            avg_q[div_s_q] <= div_quo_d[VW-1:0];
            div_s_q        <= 1'b1;
            state_q        <= div_s_q ? S_OUT : S_DIV_INIT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            for (int k = 0; k < 3; k++) begin
              o_cnt_q[k] <= OW'({{OW{1'b0}}, cnt_q[k]});
            end
            for (int s = 0; s < 2; s++) begin
              o_min_q[s] <= min_q[s];
              o_max_q[s] <= max_q[s];
              o_avg_q[s] <= avg_q[s];
            end
            o_ovf_q <= overflow_q;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_count_o        = o_cnt_q[0];
  assign failed_count_o    = o_cnt_q[1];
  assign cancelled_count_o = o_cnt_q[2];
  assign wait_min_ms_o     = o_min_q[0];
  assign wait_max_ms_o     = o_max_q[0];
  assign wait_avg_ms_o     = o_avg_q[0];
  assign exec_min_ms_o     = o_min_q[1];
  assign exec_max_ms_o     = o_max_q[1];
  assign exec_avg_ms_o     = o_avg_q[1];
  assign overflow_o        = o_ovf_q;

endmodule
